/* design/imse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imse_pkg
// Shared types, constants and helpers of the image MSE and PSNR block.
// ----------------------------------------------------------------------------
package imse_pkg;

   localparam int SIDE_W      = 13;
   localparam int CNT_W       = 25;
   localparam int SUM_W       = 40;
   localparam int LOG_W       = 38;
   localparam int MSE_W       = 24;
   localparam int PSNR_W      = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [SIDE_W-1:0] MAX_SIDE      = 13'd4096;
   localparam logic [SIDE_W-1:0] WIDTH_RESET   = 13'd640;
   localparam logic [SIDE_W-1:0] HEIGHT_RESET  = 13'd480;
   localparam logic [CNT_W-1:0]  TOTAL_RESET   = 25'd307200;
   localparam logic [15:0]       PEAK_SQ       = 16'd65025;
   localparam logic [29:0]       DB_PER_LOG2   = 30'd808071242;
   localparam logic [PSNR_W-1:0] PSNR_IDENT    = 16'hFF00;
   localparam logic [PSNR_W-1:0] PSNR_MAX      = 16'h7FFF;
   localparam logic [MSE_W-1:0]  MSE_MAX       = 24'hFFFFFF;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic [CNT_W-1:0] n;
      logic [SUM_W-1:0] s;
   } job_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      r = v;
      if (v == '0) r = 13'd1;
      else if (v > MAX_SIDE) r = MAX_SIDE;
      return r;
   endfunction

endpackage

/* design/imse_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imse_stream_if
// Valid/ready channels for pixel pairs and for image results.
// ----------------------------------------------------------------------------
interface imse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_a;
   logic [7:0] pixel_b;
   modport source (output valid, output pixel_a, output pixel_b, input ready);
   modport sink   (input valid, input pixel_a, input pixel_b, output ready);
endinterface

interface imse_rsp_if;
   logic               valid;
   logic               ready;
   logic [23:0]        mse_q8;
   logic signed [15:0] psnr_q8;
   logic               identical;
   modport source (output valid, output mse_q8, output psnr_q8, output identical,
                   input ready);
   modport sink   (input valid, input mse_q8, input psnr_q8, input identical,
                   output ready);
endinterface

/* design/imse_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imse_front
// Size registers and the per-word accumulator of squared differences.
// ----------------------------------------------------------------------------
module imse_front import imse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   imse_req_if.sink         req_if,
   input  queue_status_type q_status,
   output logic             q_push,
   output job_type          q_data
);

   logic [SIDE_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [SUM_W-1:0]  sum_ff, sum_in, sum_add;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_add;
   logic [7:0]        diff;
   logic [15:0]       sq;
   logic [25:0]       prod;
   logic              wr, accept, done;

   assign wr     = psel & penable & pwrite;
   assign prdata = (paddr[2] == REG_HEIGHT) ? {19'd0, height_ff} : {19'd0, width_ff};

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      prod      = {1'b0, side_clamp(width_ff)} * {13'd0, side_clamp(height_ff)};
      if (wr && paddr[2] == REG_WIDTH) begin
         width_in = pwdata[SIDE_W-1:0];
         prod     = {1'b0, side_clamp(pwdata[SIDE_W-1:0])} * {13'd0, side_clamp(height_ff)};
      end else if (wr && paddr[2] == REG_HEIGHT) begin
         height_in = pwdata[SIDE_W-1:0];
         prod      = {1'b0, side_clamp(width_ff)} * {13'd0, side_clamp(pwdata[SIDE_W-1:0])};
      end
      total_in = prod[CNT_W-1:0];
   end

   assign req_if.ready = ~q_status.full;
   assign accept       = req_if.valid & req_if.ready;
   assign diff         = (req_if.pixel_a > req_if.pixel_b) ? req_if.pixel_a - req_if.pixel_b
                                                           : req_if.pixel_b - req_if.pixel_a;
   assign sq           = {8'd0, diff} * {8'd0, diff};
   assign sum_add      = sum_ff + {24'd0, sq};
   assign cnt_add      = cnt_ff + 25'd1;
   assign done         = (cnt_add != '0) && (cnt_add >= total_ff);
   assign q_push       = accept & done;
   assign q_data       = '{n: cnt_add, s: sum_add};

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         sum_in = done ? '0 : sum_add;
         cnt_in = done ? '0 : cnt_add;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         total_ff  <= TOTAL_RESET;
         sum_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         total_ff  <= total_in;
         sum_ff    <= sum_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* design/imse_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imse_queue
// Short queue of finished image totals between the front and back parts.
// ----------------------------------------------------------------------------
module imse_queue import imse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_data,
   input  logic             pop,
   output job_type          pop_data,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_push, do_pop;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == QUEUE_DEPTH[PTR_W:0]);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & status.valid;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{PTR_W{1'b0}}, do_push} - {{PTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/imse_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imse_back
// Per-image sequencer: MSE by restoring division, PSNR by two log2 passes.
// ----------------------------------------------------------------------------
module imse_back import imse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          q_data,
   output logic             q_pop,
   imse_rsp_if.source       rsp_if
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCALE = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_NORM  = 4'd3;
   localparam logic [3:0] S_LOG   = 4'd4;
   localparam logic [3:0] S_DIFF  = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_DONE  = 4'd7;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [SUM_W-1:0]  s_ff, s_in;
   logic [SUM_W-1:0]  x_ff, x_in;
   logic [47:0]       dvd_ff, dvd_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [5:0]        it_ff, it_in;
   logic [SUM_W-1:0]  norm_ff, norm_in;
   logic [5:0]        e_ff, e_in;
   logic [31:0]       m_ff, m_in, frac_ff, frac_in, frac_nx;
   logic              sel_ff, sel_in;
   logic [LOG_W-1:0]  lx_ff, lx_in, ly_ff, ly_in;
   logic [29:0]       dq_ff, dq_in;
   logic [MSE_W-1:0]  mse_ff, mse_in;
   logic [PSNR_W-1:0] psnr_ff, psnr_in;
   logic              ident_ff, ident_in;
   logic              rv_ff, rv_in;
   logic [23:0]       omse_ff, omse_in;
   logic [15:0]       opsnr_ff, opsnr_in;
   logic              oident_ff, oident_in;
   logic [25:0]       rem_t;
   logic [63:0]       sq;
   logic [59:0]       pm;
   logic [40:0]       xs;

   assign rem_t = {rem_ff, dvd_ff[47]};
   assign sq    = {32'd0, m_ff} * {32'd0, m_ff};
   assign pm    = {30'd0, dq_ff} * {30'd0, DB_PER_LOG2};
   assign xs    = {25'd0, PEAK_SQ} * {16'd0, n_ff};
   assign frac_nx = {frac_ff[30:0], sq[63]};

   assign rsp_if.valid     = rv_ff;
   assign rsp_if.mse_q8    = omse_ff;
   assign rsp_if.psnr_q8   = opsnr_ff;
   assign rsp_if.identical = oident_ff;

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; s_in = s_ff; x_in = x_ff;
      dvd_in = dvd_ff; rem_in = rem_ff; it_in = it_ff;
      norm_in = norm_ff; e_in = e_ff; m_in = m_ff; frac_in = frac_ff;
      sel_in = sel_ff; lx_in = lx_ff; ly_in = ly_ff; dq_in = dq_ff;
      mse_in = mse_ff; psnr_in = psnr_ff; ident_in = ident_ff;
      rv_in = rv_ff & ~rsp_if.ready;
      omse_in = omse_ff; opsnr_in = opsnr_ff; oident_in = oident_ff;
      q_pop = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_status.valid) begin
               q_pop = 1'b1;
               n_in  = q_data.n;
               s_in  = q_data.s;
               if (q_data.s == '0) begin
                  mse_in   = '0;
                  psnr_in  = PSNR_IDENT;
                  ident_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  ident_in = 1'b0;
                  state_in = S_SCALE;
               end
            end
         end
         S_SCALE: begin
            x_in     = xs[SUM_W-1:0];
            dvd_in   = {s_ff, 8'd0};
            rem_in   = '0;
            it_in    = 6'd47;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_t >= {1'b0, n_ff}) begin
               rem_in = rem_t[CNT_W-1:0] - n_ff;
               dvd_in = {dvd_ff[46:0], 1'b1};
            end else begin
               rem_in = rem_t[CNT_W-1:0];
               dvd_in = {dvd_ff[46:0], 1'b0};
            end
            it_in = it_ff - 6'd1;
            if (it_ff == '0) begin
               mse_in   = (dvd_in[47:24] != '0) ? MSE_MAX : dvd_in[23:0];
               norm_in  = x_ff;
               e_in     = 6'd39;
               sel_in   = 1'b0;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (norm_ff[SUM_W-1]) begin
               m_in     = norm_ff[39:8];
               frac_in  = '0;
               it_in    = 6'd31;
               state_in = S_LOG;
            end else begin
               norm_in = {norm_ff[SUM_W-2:0], 1'b0};
               e_in    = e_ff - 6'd1;
            end
         end
         S_LOG: begin
            m_in    = sq[63] ? sq[63:32] : sq[62:31];
            frac_in = frac_nx;
            it_in   = it_ff - 6'd1;
            if (it_ff == '0) begin
               if (!sel_ff) begin
                  lx_in    = {e_ff, frac_nx};
                  norm_in  = s_ff;
                  e_in     = 6'd39;
                  sel_in   = 1'b1;
                  state_in = S_NORM;
               end else begin
                  ly_in    = {e_ff, frac_nx};
                  state_in = S_DIFF;
               end
            end
         end
         S_DIFF: begin
            dq_in    = (lx_ff > ly_ff) ? lx_ff[37:8] - ly_ff[37:8]
                                         - {29'd0, (lx_ff[7:0] < ly_ff[7:0])} : '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            psnr_in  = pm[59] ? PSNR_MAX : (pm[58:44] > 15'h7FFF ? PSNR_MAX
                                                                : {1'b0, pm[58:44]});
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rv_ff || rsp_if.ready) begin
               rv_in     = 1'b1;
               omse_in   = mse_ff;
               opsnr_in  = psnr_ff;
               oident_in = ident_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; s_ff <= s_in; x_ff <= x_in;
      dvd_ff <= dvd_in; rem_ff <= rem_in; it_ff <= it_in;
      norm_ff <= norm_in; e_ff <= e_in; m_ff <= m_in; frac_ff <= frac_in;
      sel_ff <= sel_in; lx_ff <= lx_in; ly_ff <= ly_in; dq_ff <= dq_in;
      mse_ff <= mse_in; psnr_ff <= psnr_in; ident_ff <= ident_in;
      omse_ff <= omse_in; opsnr_ff <= opsnr_in; oident_ff <= oident_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

endmodule

/* design/image_mse_psnr_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_mse_psnr_top
// Mean squared error and PSNR of two 8-bit grayscale images.
// ----------------------------------------------------------------------------
// Pixel pairs are taken one word per cycle while the queue of image totals has room.
// A result of an identical image skips the division and log2 passes; any other takes
// 48 division steps, two log2 passes of squaring steps each after a normalize shift,
// and setup and output states, plus any earlier image still in the shared sequencer.
// Reset sets the sizes to 640 by 480 and clears the sums, queue and output.
module image_mse_psnr_top import imse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   imse_req_if.sink    req_if,
   imse_rsp_if.source  rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   queue_status_type q_status;
   logic             q_push, q_pop;
   job_type          q_in, q_out;

   assign pready = 1'b1;

   imse_front u_front (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
      .req_if, .q_status, .q_push, .q_data(q_in)
   );

   imse_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .pop(q_pop),
      .pop_data(q_out), .status(q_status)
   );

   imse_back u_back (
      .clock, .reset, .q_status, .q_data(q_out), .q_pop, .rsp_if
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full) else $error("Push into a full queue.");

   a_ident_result: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.identical |->
         rsp_if.psnr_q8 == PSNR_IDENT && rsp_if.mse_q8 == '0)
      else $error("Identical result with wrong fields.");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid) else $error("Result valid after reset.");

endmodule

/* sim/tb_image_mse_psnr_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_mse_psnr_top
// Self-checking testbench of the image MSE and PSNR block.
// ----------------------------------------------------------------------------
// Pixel words are queued by a stimulus process and offered by a driver with
// random gaps, while the result side stalls at random. Every accepted word
// feeds a local model of the accumulator, which predicts each image result.
// The monitor compares results field by field, the PSNR within one LSB.
// Image sizes are changed only while the block is idle, including while an
// image is partly taken, and cover zero, small and oversized sides.
// ----------------------------------------------------------------------------
module tb_image_mse_psnr_top;
   import imse_pkg::*;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
   } pixel_pair_t;

   typedef struct packed {
      logic [MSE_W-1:0]  mse;
      logic [PSNR_W-1:0] psnr;
      logic              ident;
   } image_result_t;

   typedef enum int {PIX_RANDOM, PIX_EQUAL, PIX_NEAR, PIX_FAR} pixel_kind_t;

   localparam int      HALF_PERIOD  = 2;
   localparam int      DRAIN_CYCLES = 250;
   localparam int      WORD_TARGET  = 1750;
   localparam longint  CYCLE_LIMIT  = 1500000;
   localparam logic [2:0] ADDR_WIDTH  = 3'd0;
   localparam logic [2:0] ADDR_HEIGHT = 3'd4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   imse_req_if req_if ();
   imse_rsp_if rsp_if ();

   image_mse_psnr_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if.sink),
      .rsp_if  (rsp_if.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   pixel_pair_t   pending_pairs[$];
   image_result_t expected_images[$];

   logic [SIDE_W-1:0] model_width = WIDTH_RESET;
   logic [SIDE_W-1:0] model_height = HEIGHT_RESET;
   logic [SUM_W-1:0]  model_sum = '0;
   logic [CNT_W-1:0]  model_count = '0;

   int     error_count = 0;
   int     images_checked = 0;
   int     words_taken = 0;
   longint cycle_count = 0;
   bit     quiet = 1'b0;
   int     send_gap = 0;
   int     stall_left = 0;
   int     hold_left = 0;
   bit     hold_start = 1'b0;

   initial begin
      req_if.valid = 1'b0;
      req_if.pixel_a = '0;
      req_if.pixel_b = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic longint unsigned clamp_side(logic [SIDE_W-1:0] v);
      longint unsigned r;
      r = v;
      if (r == 0) r = 1;
      else if (r > 4096) r = 4096;
      return r;
   endfunction

   function automatic longint unsigned log2_fixed(longint unsigned v);
      int              e;
      longint unsigned m;
      longint unsigned frac;
      e = 0;
      frac = 0;
      while (e < 63 && (v >> (e + 1)) != 0) e++;
      if (e >= 31) m = v >> (e - 31);
      else m = v << (31 - e);
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return (longint'(e) << 32) | frac;
   endfunction

   task automatic accumulate_pair(pixel_pair_t p);
      longint unsigned d, total, n, s, lx, ly, diff, mse, psnr;
      image_result_t   r;
      d = (p.a > p.b) ? p.a - p.b : p.b - p.a;
      total = clamp_side(model_width) * clamp_side(model_height);
      model_sum = model_sum + SUM_W'(d * d);
      model_count = model_count + 1'b1;
      if (model_count != 0 && model_count >= total) begin
         n = model_count;
         s = model_sum;
         model_sum = '0;
         model_count = '0;
         if (s == 0) begin
            r.mse = '0;
            r.psnr = PSNR_IDENT;
            r.ident = 1'b1;
         end else begin
            lx = log2_fixed(64'd65025 * n);
            ly = log2_fixed(s);
            diff = (lx > ly) ? lx - ly : 0;
            mse = (s << 8) / n;
            if (mse > 64'hFFFFFF) mse = 64'hFFFFFF;
            psnr = ((diff >> 8) * 64'd808071242) >> 44;
            if (psnr > 32767) psnr = 32767;
            r.mse = mse[MSE_W-1:0];
            r.psnr = psnr[PSNR_W-1:0];
            r.ident = 1'b0;
         end
         expected_images.push_back(r);
      end
   endtask

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Request side: offer the head of the queue, drop it once taken.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         accumulate_pair(pending_pairs.pop_front());
         words_taken++;
         send_gap = random_gap();
      end
   end

   always @(negedge clock) begin
      if (reset || pending_pairs.size() == 0) begin
         req_if.valid <= 1'b0;
      end else if (send_gap > 0) begin
         send_gap--;
         req_if.valid <= 1'b0;
      end else begin
         req_if.valid <= 1'b1;
         req_if.pixel_a <= pending_pairs[0].a;
         req_if.pixel_b <= pending_pairs[0].b;
      end
   end

   always @(posedge clock) begin
      if (hold_start) hold_left <= 3000;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   always @(negedge clock) begin
      if (reset || hold_left > 0) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         stall_left = random_gap();
         rsp_if.ready <= (stall_left == 0);
      end
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH image %0d %s: got %0d expected %0d", images_checked, what, got,
               want);
      error_count++;
   endtask

   always @(posedge clock) begin
      image_result_t want;
      int            delta;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_images.size() == 0) begin
            report_mismatch("unexpected result, mse", rsp_if.mse_q8, 0);
         end else begin
            want = expected_images.pop_front();
            delta = int'(rsp_if.psnr_q8) - int'($signed(want.psnr));
            if (rsp_if.mse_q8 !== want.mse) report_mismatch("mse_q8", rsp_if.mse_q8, want.mse);
            if (rsp_if.identical !== want.ident)
               report_mismatch("identical", rsp_if.identical, want.ident);
            if ($isunknown(rsp_if.psnr_q8) || (want.ident ? delta != 0 : (delta > 1 || delta < -1)))
               report_mismatch("psnr_q8", rsp_if.psnr_q8, $signed(want.psnr));
         end
         images_checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_register(logic [2:0] addr, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (addr == ADDR_WIDTH) model_width = value[SIDE_W-1:0];
      else model_height = value[SIDE_W-1:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_pairs.size() != 0 || expected_images.size() != 0 || hold_left > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_size(int w, int h);
      wait_idle();
      write_register(ADDR_WIDTH, w);
      write_register(ADDR_HEIGHT, h);
   endtask

   task automatic queue_pairs(pixel_kind_t kind, int count);
      pixel_pair_t p;
      for (int i = 0; i < count; i++) begin
         p.a = $urandom_range(0, 255);
         case (kind)
            PIX_RANDOM: p.b = $urandom_range(0, 255);
            PIX_EQUAL:  p.b = p.a;
            PIX_NEAR:   p.b = p.a ^ 8'($urandom_range(0, 3));
            default: begin
               p.a = {8{p.a[0]}};
               p.b = ~p.a;
            end
         endcase
         pending_pairs.push_back(p);
      end
   endtask

   initial begin
      int w, h, k, pixels;
      pixel_pair_t p;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: one-pixel images with walking bits and extremes.
      set_size(0, 0);
      for (int i = 0; i < 8; i++) begin
         p.a = 8'd1 << i;
         p.b = ~p.a;
         pending_pairs.push_back(p);
      end
      p = '{8'd0, 8'd255};   pending_pairs.push_back(p);
      p = '{8'd255, 8'd0};   pending_pairs.push_back(p);
      p = '{8'd255, 8'd255}; pending_pairs.push_back(p);
      p = '{8'd0, 8'd0};     pending_pairs.push_back(p);
      set_size(3, 2);
      queue_pairs(PIX_FAR, 6);
      queue_pairs(PIX_EQUAL, 6);
      queue_pairs(PIX_RANDOM, 4);
      // Shrink the image while four pixels are already counted.
      set_size(2, 1);
      queue_pairs(PIX_NEAR, 3);

      // Width written above the limit, then the image is cut short by a resize.
      set_size(8191, 1);
      queue_pairs(PIX_NEAR, 1000);
      set_size(3, 1);
      queue_pairs(PIX_RANDOM, 1);

      // Result side held off while tiny images keep arriving.
      set_size(1, 1);
      @(negedge clock);
      hold_start <= 1'b1;
      @(negedge clock);
      hold_start <= 1'b0;
      queue_pairs(PIX_RANDOM, 40);

      while (words_taken + pending_pairs.size() < WORD_TARGET) begin
         k = $urandom_range(0, 9);
         w = (k == 0) ? 0 : (k == 1) ? $urandom_range(7, 24) : $urandom_range(1, 6);
         h = (k == 2) ? 0 : (k == 3) ? $urandom_range(7, 16) : $urandom_range(1, 6);
         set_size(w, h);
         quiet = ($urandom_range(0, 5) == 0);
         pixels = int'(clamp_side(SIDE_W'(w)) * clamp_side(SIDE_W'(h)));
         for (int img = $urandom_range(1, 5); img > 0; img--)
            queue_pairs(pixel_kind_t'($urandom_range(0, 3)), pixels);
         if ($urandom_range(0, 2) == 0)
            queue_pairs(PIX_RANDOM, $urandom_range(1, pixels));
      end

      set_size(WIDTH_RESET, HEIGHT_RESET);
      queue_pairs(PIX_RANDOM, 100);
      set_size(1, 1);
      wait_idle();

      $display("Covered %0d pixel words and %0d image results over many image sizes,",
               words_taken, images_checked);
      $display("with random gaps, stalls, a long result hold-off and resizes mid-image.");
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* image_mse_psnr_top.f */
design/imse_pkg.sv
design/imse_stream_if.sv
design/imse_front.sv
design/imse_queue.sv
design/imse_back.sv
design/image_mse_psnr_top.sv
sim/tb_image_mse_psnr_top.sv
